[rtl/core/yfmse_pkg.sv]
// Shared types, widths and codes for the YUV 4:2:0 frame MSE block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package yfmse_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int FP_W         = 25;
    localparam int MSE_W        = 40;
    localparam int LUMA_SUM_W   = 56;
    localparam int CHROMA_SUM_W = 54;
    localparam int SQ_W         = 2 * SAMPLE_W;
    localparam int PLANE_W      = 2;

    localparam int MIN_FRAME_PIXELS     = 4;
    localparam int DEF_MAX_FRAME_PIXELS = 16777216;
    localparam int DEF_FRACTION_BITS    = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = 1'b1;

    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ref_sample;
        logic [SAMPLE_W-1:0] test_sample;
    } sample_t;

    typedef struct packed {
        logic [MSE_W-1:0] luma_mse;
        logic [MSE_W-1:0] mse_cr;
        logic [MSE_W-1:0] mse_cb;
    } result_t;

    // One finished frame waiting for its divisions.
    typedef struct packed {
        logic [LUMA_SUM_W-1:0]   luma_sum;
        logic [CHROMA_SUM_W-1:0] cr_sum;
        logic [CHROMA_SUM_W-1:0] cb_sum;
        logic [FP_W-1:0]         pixels;
    } job_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_FINISH
    } back_state_t;

endpackage

`default_nettype wire

[rtl/core/yfmse_front.sv]
// Front end: configuration registers, sample classification and the
// per-plane sums of squared differences. Depends on yfmse_pkg.
`default_nettype none

module yfmse_front
    import yfmse_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    input  wire sample_t               sample,
    output logic                       full,
    input  wire queue_status_t         q_status,
    output logic                       q_push,
    output job_t                       q_job
);

    logic [FP_W-1:0] frame_pixels_reg;
    logic            sample_mode_reg;

    logic [FP_W-1:0]    index_reg, index_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;

    logic                s1_valid_reg;
    logic                s1_end_reg;
    logic [PLANE_W-1:0]  s1_plane_reg;
    logic [SAMPLE_W-1:0] s1_diff_reg;
    logic [FP_W-1:0]     s1_pixels_reg;

    logic                s2_valid_reg;
    logic                s2_end_reg;
    logic [PLANE_W-1:0]  s2_plane_reg;
    logic [SQ_W-1:0]     s2_sq_reg;
    logic [FP_W-1:0]     s2_pixels_reg;

    logic [LUMA_SUM_W-1:0]   luma_sum_reg, luma_sum_next, luma_upd;
    logic [CHROMA_SUM_W-1:0] cr_sum_reg, cr_sum_next, cr_upd;
    logic [CHROMA_SUM_W-1:0] cb_sum_reg, cb_sum_next, cb_upd;

    logic                accept;
    logic [SAMPLE_W-1:0] a_val, b_val, diff;
    logic [FP_W-1:0]     n_eff, limit, index_inc;
    logic                plane_done, frame_end;
    logic [QCNT_W+1:0]   slots_used;

    // A frame end in flight must find a free queue entry when it arrives.
    assign slots_used = (QCNT_W+2)'(q_status.count)
                      + (QCNT_W+2)'(s1_valid_reg & s1_end_reg)
                      + (QCNT_W+2)'(s2_valid_reg & s2_end_reg);
    assign full   = slots_used >= (QCNT_W+2)'(QUEUE_DEPTH);
    assign accept = push & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FP_W'(MIN_FRAME_PIXELS);
            sample_mode_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_PIXELS: frame_pixels_reg <= cfg_data[FP_W-1:0];
                CFG_SAMPLE_MODE:  sample_mode_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        a_val = sample_mode_reg ? sample.ref_sample
                                : {8'h00, sample.ref_sample[7:0]};
        b_val = sample_mode_reg ? sample.test_sample
                                : {8'h00, sample.test_sample[7:0]};
        diff  = (a_val > b_val) ? (a_val - b_val) : (b_val - a_val);

        if (frame_pixels_reg < FP_W'(MIN_FRAME_PIXELS))
            n_eff = FP_W'(MIN_FRAME_PIXELS);
        else if (frame_pixels_reg > FP_W'(MAX_FRAME_PIXELS))
            n_eff = FP_W'(MAX_FRAME_PIXELS);
        else
            n_eff = frame_pixels_reg;

        limit      = (plane_reg == PLANE_LUMA) ? n_eff : (n_eff >> 2);
        index_inc  = index_reg + FP_W'(1);
        plane_done = index_inc >= limit;
        frame_end  = plane_done && !(plane_reg inside {PLANE_LUMA, PLANE_CR});

        index_next = index_reg;
        plane_next = plane_reg;
        if (accept)
        begin
            index_next = plane_done ? '0 : index_inc;
            if (plane_done)
                plane_next = frame_end ? PLANE_LUMA : plane_reg + PLANE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            plane_reg    <= PLANE_LUMA;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg    <= index_next;
            plane_reg    <= plane_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_end_reg    <= frame_end;
            s1_plane_reg  <= plane_reg;
            s1_diff_reg   <= diff;
            s1_pixels_reg <= n_eff;
        end
        if (s1_valid_reg)
        begin
            s2_end_reg    <= s1_end_reg;
            s2_plane_reg  <= s1_plane_reg;
            s2_sq_reg     <= s1_diff_reg * s1_diff_reg;
            s2_pixels_reg <= s1_pixels_reg;
        end
    end

    always_comb
    begin
        luma_upd = luma_sum_reg;
        cr_upd   = cr_sum_reg;
        cb_upd   = cb_sum_reg;
        case (s2_plane_reg)
            PLANE_LUMA: luma_upd = luma_sum_reg + LUMA_SUM_W'(s2_sq_reg);
            PLANE_CR:   cr_upd   = cr_sum_reg + CHROMA_SUM_W'(s2_sq_reg);
            default:    cb_upd   = cb_sum_reg + CHROMA_SUM_W'(s2_sq_reg);
        endcase

        q_push         = s2_valid_reg & s2_end_reg;
        q_job.luma_sum = luma_upd;
        q_job.cr_sum   = cr_upd;
        q_job.cb_sum   = cb_upd;
        q_job.pixels   = s2_pixels_reg;

        luma_sum_next = luma_sum_reg;
        cr_sum_next   = cr_sum_reg;
        cb_sum_next   = cb_sum_reg;
        if (s2_valid_reg)
        begin
            luma_sum_next = s2_end_reg ? '0 : luma_upd;
            cr_sum_next   = s2_end_reg ? '0 : cr_upd;
            cb_sum_next   = s2_end_reg ? '0 : cb_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_sum_reg <= '0;
            cr_sum_reg   <= '0;
            cb_sum_reg   <= '0;
        end
        else
        begin
            luma_sum_reg <= luma_sum_next;
            cr_sum_reg   <= cr_sum_next;
            cb_sum_reg   <= cb_sum_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/yfmse_fifo.sv]
// Short queue of finished-frame sums between the front and back ends.
// Depends on yfmse_pkg; the head item is read out into a register on pop.
`default_nettype none

module yfmse_fifo
    import yfmse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire job_t      wr_data,
    input  wire logic      pop,
    output job_t           rd_data,
    output queue_status_t  status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    job_t              mem [QUEUE_DEPTH];
    job_t              rd_data_reg;
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
        if (pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign rd_data      = rd_data_reg;
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("frame queue written while holding every entry");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("frame queue read while empty");
`endif

endmodule

`default_nettype wire

[rtl/core/yfmse_back.sv]
// Back end: one restoring divider shared by the three planes, and the
// result register. Depends on yfmse_pkg.
`default_nettype none

module yfmse_back
    import yfmse_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t q_status,
    output logic               q_pop,
    input  wire job_t          q_job,
    output logic               empty,
    input  wire logic          pop,
    output result_t            result
);

    localparam int DIV_W  = LUMA_SUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int REM_W  = FP_W + 1;

    back_state_t state_reg, state_next;

    logic                    load_job, do_step, last_step, load_out;
    logic [PLANE_W-1:0]      plane_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [DIV_W-1:0]        dvd_reg;
    logic [FP_W-1:0]         divisor_reg, chroma_div_reg;
    logic [FP_W-1:0]         rem_reg;
    logic [REM_W-1:0]        rem_sh, rem_new;
    logic [MSE_W-1:0]        quo_reg, quo_new, mean;
    logic                    ovf_reg, ovf_new, ge;
    logic [CHROMA_SUM_W-1:0] cr_sum_reg, cb_sum_reg;
    logic [MSE_W-1:0]        luma_res_reg, cr_res_reg, cb_res_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (!q_status.empty) state_next = BK_LOAD;
            BK_LOAD:   state_next = BK_DIV;
            BK_DIV:    if (last_step && plane_reg == PLANE_CB) state_next = BK_FINISH;
            BK_FINISH: if (!out_valid_reg) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load_job  = 1'b0;
        do_step   = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            BK_IDLE:   q_pop    = ~q_status.empty;
            BK_LOAD:   load_job = 1'b1;
            BK_DIV:    do_step  = 1'b1;
            BK_FINISH: load_out = ~out_valid_reg;
            default:   ;
        endcase
        last_step = do_step && (step_reg == STEP_W'(DIV_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // One quotient bit a cycle, most significant first. A bit that would
    // fall off the top of the 40-bit quotient marks the mean as saturated.
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
        ge      = rem_sh >= {1'b0, divisor_reg};
        rem_new = ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
        quo_new = {quo_reg[MSE_W-2:0], ge};
        ovf_new = ovf_reg | quo_reg[MSE_W-1];
        mean    = ovf_new ? '1 : quo_new;
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            plane_reg      <= PLANE_LUMA;
            dvd_reg        <= DIV_W'(q_job.luma_sum) << FRACTION_BITS;
            divisor_reg    <= q_job.pixels;
            chroma_div_reg <= q_job.pixels >> 2;
            cr_sum_reg     <= q_job.cr_sum;
            cb_sum_reg     <= q_job.cb_sum;
            step_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (do_step)
        begin
            if (last_step)
            begin
                step_reg    <= '0;
                rem_reg     <= '0;
                quo_reg     <= '0;
                ovf_reg     <= 1'b0;
                divisor_reg <= chroma_div_reg;
                plane_reg   <= plane_reg + PLANE_W'(1);
                case (plane_reg)
                    PLANE_LUMA:
                    begin
                        luma_res_reg <= mean;
                        dvd_reg      <= DIV_W'(cr_sum_reg) << FRACTION_BITS;
                    end
                    PLANE_CR:
                    begin
                        cr_res_reg <= mean;
                        dvd_reg    <= DIV_W'(cb_sum_reg) << FRACTION_BITS;
                    end
                    default:
                    begin
                        cb_res_reg <= mean;
                    end
                endcase
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
                dvd_reg  <= dvd_reg << 1;
                // The remainder stays below the divisor, so its top bit is clear.
                rem_reg  <= rem_new[FP_W-1:0];
                quo_reg  <= quo_new;
                ovf_reg  <= ovf_new;
            end
        end
        if (load_out)
        begin
            out_reg.luma_mse <= luma_res_reg;
            out_reg.mse_cr   <= cr_res_reg;
            out_reg.mse_cb   <= cb_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty  = ~out_valid_reg;
    assign result = out_reg;

`ifndef NO_ASSERTIONS
    a_load_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD) |-> ($past(state_reg) == BK_IDLE))
        else $error("job loaded without a queue read the cycle before");

    a_finish_after_cb: assert property (@(posedge clk) disable iff (!rst_n)
        (last_step && plane_reg == PLANE_CB) |=> (state_reg == BK_FINISH))
        else $error("second chroma division ended without finishing the frame");
`endif

endmodule

`default_nettype wire

[rtl/core/yuv420_frame_mse_top.sv]
// Top level of the YUV 4:2:0 frame MSE block: front end, frame queue and
// divider back end. Depends on yfmse_pkg, yfmse_front, yfmse_fifo, yfmse_back.
`default_nettype none

// Sample pairs are taken at one item per cycle whenever full is low: luma
// pairs first, then the two chroma planes of frame_pixels/4 pairs each. The
// front end squares and accumulates in a three-stage pipeline, so full is
// set only when the two-entry frame queue is spoken for by finished frames.
// Each finished frame then passes through the back end's restoring
// divider, which is shared by the three planes and gives one quotient
// bit a cycle; its result item waits in an output register until
// popped. cfg_ready is always high, and registers should be written only
// while no frame is in progress. No clearing pass is needed after reset.
module yuv420_frame_mse_top
    import yfmse_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire sample_t               sample,
    output logic                       empty,
    input  wire logic                  pop,
    output result_t                    result
);

    queue_status_t q_status;
    logic          q_push, q_pop;
    job_t          q_wr_job, q_rd_job;

    assign cfg_ready = 1'b1;

    yfmse_front #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .full      (full),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_job     (q_wr_job)
    );

    yfmse_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_job),
        .pop     (q_pop),
        .rd_data (q_rd_job),
        .status  (q_status)
    );

    yfmse_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_pop    (q_pop),
        .q_job    (q_rd_job),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire
